// File: hdl/aop_pkg.sv
// aop_pkg: shared types and constants of the alignment order permuter
// used by aop_ctrl, aop_dpath and alignment_order_permuter_top
`default_nettype none
package aop_pkg;

  localparam int MAX_WORDS_DEF = 64;
  localparam int VAL_W         = 12;
  localparam int KEY_W         = 9;
  localparam int TGT_W         = 8;
  localparam int MODE_W        = 2;

  localparam logic [MODE_W-1:0] MODE_IDENT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LEFT  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RIGHT = 2'd2;

  // key with no aligned target, also the "none found" mark of a sort pass
  localparam logic [KEY_W-1:0] KEY_NONE = 9'h100;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SCAN,
    ST_FILL,
    ST_SORT
  } st_t;

  typedef struct packed {
    st_t  op;
    logic init;
    logic init_rev;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic last_acc;
    logic step_end;
    logic do_fill;
    logic rev;
    logic sent_last;
  } status_t;

endpackage
`default_nettype wire

// File: hdl/aop_ctrl.sv
// aop_ctrl: sentence sequencer, load / scan / fill / sort
// depends on aop_pkg, drives aop_dpath through cmd_t
`default_nettype none
module aop_ctrl (
  input  wire            clk,
  input  wire            rst_n,
  input  aop_pkg::status_t sts,
  output aop_pkg::cmd_t  cmd
);
  import aop_pkg::*;

  st_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_LOAD;
    else        state_r <= state_nxt;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: if (sts.last_acc) state_nxt = ST_SCAN;
      ST_SCAN: if (sts.step_end) state_nxt = sts.do_fill ? ST_FILL : ST_SORT;
      ST_FILL: if (sts.step_end) state_nxt = ST_SORT;
      ST_SORT: if (sts.sent_last) state_nxt = ST_LOAD;
      default: state_nxt = ST_LOAD;
    endcase
  end

  // commands
  always_comb begin
    cmd.op       = state_r;
    cmd.init     = 1'b0;
    cmd.init_rev = 1'b0;
    cmd.clear    = 1'b0;
    unique case (state_r)
      ST_LOAD: cmd.init = sts.last_acc;
      ST_SCAN: begin
        cmd.init     = sts.step_end;
        cmd.init_rev = sts.step_end && sts.do_fill && sts.rev;
      end
      ST_FILL: cmd.init  = sts.step_end;
      ST_SORT: cmd.clear = sts.sent_last;
      default: cmd.init  = 1'b0;
    endcase
  end

endmodule
`default_nettype wire

// File: hdl/aop_dpath.sv
// aop_dpath: word stores, walk counter, key scan, fill and sort passes, result register
// depends on aop_pkg, sequenced by aop_ctrl
`default_nettype none
module aop_dpath #(
  parameter int MAX_WORDS = aop_pkg::MAX_WORDS_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  aop_pkg::cmd_t                cmd,
  output aop_pkg::status_t             sts,
  input  wire                          cfg_we,
  input  wire [aop_pkg::MODE_W-1:0]    cfg_wdata,
  input  wire                          in_acc,
  input  wire [aop_pkg::VAL_W-1:0]     in_word_value,
  input  wire                          in_is_aligned,
  input  wire [aop_pkg::TGT_W-1:0]     in_target_index,
  input  wire                          in_last_word,
  output logic                         out_valid,
  input  wire                          out_stall,
  output logic [aop_pkg::VAL_W-1:0]    out_value,
  output logic                         out_last,
  output logic                         out_overflow
);
  import aop_pkg::*;

  localparam int AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int CW = $clog2(MAX_WORDS + 1);

  logic [VAL_W-1:0] vmem [MAX_WORDS];
  logic [KEY_W-1:0] kmem [MAX_WORDS];

  logic [MODE_W-1:0] mode_r;
  logic [CW-1:0]     count_r, em_cnt_r;
  logic              drop_r, any_r, ph_r;
  logic [AW-1:0]     idx_r;
  logic [VAL_W-1:0]  rd_val_r;
  logic [KEY_W-1:0]  rd_key_r;
  logic [TGT_W-1:0]  first_r, lastal_r, fill_r, cur_r;
  logic [KEY_W-1:0]  nxt_r;
  logic              out_valid_r, out_last_r, out_ovf_r;
  logic [VAL_W-1:0]  out_value_r;

  logic              store_ok, aligned_now, any_nxt, at_end, adv, emit, out_free;
  logic [TGT_W-1:0]  first_nxt, lastal_nxt, fill_val, ek;
  logic [KEY_W-1:0]  nxt_upd;
  logic [AW-1:0]     last_idx;

  // walk decode
  assign store_ok    = count_r < CW'(MAX_WORDS);
  assign last_idx    = AW'(count_r - 1'b1);
  assign aligned_now = ph_r && !rd_key_r[KEY_W-1];
  assign at_end      = (cmd.op == ST_FILL && mode_r[1]) ? (idx_r == '0) : (idx_r == last_idx);
  assign out_free    = !out_valid_r || !out_stall;
  assign ek          = (mode_r == MODE_IDENT || !any_r) ? '0 : rd_key_r[TGT_W-1:0];
  assign emit        = (cmd.op == ST_SORT) && ph_r && (ek == cur_r) && out_free;
  assign adv         = ph_r && !((cmd.op == ST_SORT) && (ek == cur_r) && !out_free);
  assign fill_val    = rd_key_r[KEY_W-1] ? fill_r : rd_key_r[TGT_W-1:0];

  // scan results, seen in the cycle they are found
  always_comb begin
    any_nxt    = any_r;
    first_nxt  = first_r;
    lastal_nxt = lastal_r;
    if (cmd.op == ST_SCAN && aligned_now) begin
      any_nxt    = 1'b1;
      lastal_nxt = rd_key_r[TGT_W-1:0];
      if (!any_r) first_nxt = rd_key_r[TGT_W-1:0];
    end
  end

  // smallest key above the current one seen so far in this pass
  always_comb begin
    nxt_upd = nxt_r;
    if (ph_r && ek > cur_r && {1'b0, ek} < nxt_r) nxt_upd = {1'b0, ek};
  end

  assign sts.last_acc  = in_acc && in_last_word;
  assign sts.step_end  = adv && at_end && (cmd.op == ST_SCAN || cmd.op == ST_FILL);
  assign sts.do_fill   = (mode_r != MODE_IDENT) && any_nxt;
  assign sts.rev       = mode_r[1];
  assign sts.sent_last = emit && (CW'(em_cnt_r + 1'b1) == count_r);

  // stores and registered read port
  always_ff @(posedge clk) begin
    if (in_acc && store_ok) vmem[count_r[AW-1:0]] <= in_word_value;
    rd_val_r <= vmem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (in_acc && store_ok)
      kmem[count_r[AW-1:0]] <= in_is_aligned ? {1'b0, in_target_index} : KEY_NONE;
    else if (cmd.op == ST_FILL && ph_r)
      kmem[idx_r] <= {1'b0, fill_val};
    rd_key_r <= kmem[idx_r];
  end

  // sentence control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_LEFT;
      count_r  <= '0;
      em_cnt_r <= '0;
      drop_r   <= 1'b0;
      any_r    <= 1'b0;
      ph_r     <= 1'b0;
      idx_r    <= '0;
    end else begin
      if (cfg_we) mode_r <= cfg_wdata;
      if (cmd.clear) begin
        count_r  <= '0;
        em_cnt_r <= '0;
        drop_r   <= 1'b0;
        any_r    <= 1'b0;
        ph_r     <= 1'b0;
        idx_r    <= '0;
      end else begin
        if (in_acc) begin
          if (store_ok) count_r <= CW'(count_r + 1'b1);
          else          drop_r  <= 1'b1;
        end
        any_r <= any_nxt;
        if (emit) em_cnt_r <= CW'(em_cnt_r + 1'b1);
        if (cmd.init) begin
          ph_r  <= 1'b0;
          idx_r <= cmd.init_rev ? last_idx : '0;
        end else if (cmd.op != ST_LOAD) begin
          if (!ph_r) ph_r <= 1'b1;
          else if (adv) begin
            ph_r <= 1'b0;
            if (cmd.op == ST_FILL && mode_r[1]) idx_r <= idx_r - 1'b1;
            else if (idx_r == last_idx)         idx_r <= '0;
            else                                idx_r <= idx_r + 1'b1;
          end
        end
      end
    end
  end

  // scan, fill and sort pass registers
  always_ff @(posedge clk) begin
    first_r  <= first_nxt;
    lastal_r <= lastal_nxt;
    if (cmd.init) begin
      fill_r <= mode_r[1] ? lastal_nxt : first_nxt;
      cur_r  <= '0;
      nxt_r  <= KEY_NONE;
    end else begin
      if (cmd.op == ST_FILL && ph_r) fill_r <= fill_val;
      if (cmd.op == ST_SORT && adv) begin
        if (idx_r == last_idx) begin
          cur_r <= nxt_upd[TGT_W-1:0];
          nxt_r <= KEY_NONE;
        end else begin
          nxt_r <= nxt_upd;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (emit) out_valid_r <= 1'b1;
    else if (!out_stall) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_value_r <= rd_val_r;
      out_last_r  <= sts.sent_last;
      out_ovf_r   <= drop_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_value    = out_value_r;
  assign out_last     = out_last_r;
  assign out_overflow = out_ovf_r;

  a_em_le_count: assert property (@(posedge clk) disable iff (!rst_n)
    em_cnt_r <= count_r) else $error("emitted more results than stored words");
  a_walk_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op != ST_LOAD) |-> (count_r != '0)) else $error("walk over empty sentence");
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    sts.sent_last |=> (count_r == '0 && !drop_r)) else $error("sentence not cleared");
  a_no_emit_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !emit) else $error("result overwritten while stalled");

endmodule
`default_nettype wire

// File: hdl/alignment_order_permuter_top.sv
// alignment_order_permuter_top: loads a sentence, fills sort keys, emits sorted values
// depends on aop_pkg, aop_ctrl and aop_dpath
//
//  port group | dir | meaning
//  in_*       | in  | one source word a beat, valid/stall
//  out_*      | out | one permuted value a beat, valid/stall
//  cfg_*      | in  | order_mode write
//
// words load at one per cycle while the block is in its load phase
// after the last word, the stored words are scanned, then filled (left or right mode,
// when any word is aligned), then walked in sort passes, one pass per distinct key,
// plus one when no key is zero; each word store has a single read port; out_stall holds a pass
// reset is synchronous active low; no word is taken from the last word until the
// final result of the sentence has been loaded into the output register
`default_nettype none
module alignment_order_permuter_top #(
  parameter int MAX_WORDS = aop_pkg::MAX_WORDS_DEF
) (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       cfg_we,
  input  wire [aop_pkg::MODE_W-1:0] cfg_wdata,
  input  wire                       in_valid,
  output logic                      in_stall,
  input  wire [aop_pkg::VAL_W-1:0]  in_word_value,
  input  wire                       in_is_aligned,
  input  wire [aop_pkg::TGT_W-1:0]  in_target_index,
  input  wire                       in_last_word,
  output logic                      out_valid,
  input  wire                       out_stall,
  output logic [aop_pkg::VAL_W-1:0] out_value,
  output logic                      out_last,
  output logic                      out_overflow
);
  import aop_pkg::*;

  cmd_t    cmd;
  status_t sts;
  logic    in_acc;

  // input beats only in the load phase
  assign in_stall = (cmd.op != ST_LOAD);
  assign in_acc   = in_valid && !in_stall;

  aop_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  aop_dpath #(.MAX_WORDS(MAX_WORDS)) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_acc          (in_acc),
    .in_word_value   (in_word_value),
    .in_is_aligned   (in_is_aligned),
    .in_target_index (in_target_index),
    .in_last_word    (in_last_word),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_value       (out_value),
    .out_last        (out_last),
    .out_overflow    (out_overflow)
  );

endmodule
`default_nettype wire
